/* rtl/qte_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and constants for the quaternion to Euler angle pipeline.
// No dependencies; every other file of the block imports this package.
package qte_pkg;

    localparam int DEF_CORDIC_STAGES = 16;
    localparam int DEF_SAMPLE_WIDTH  = 16;
    localparam int ATAN_ENTRIES      = 24;

    localparam int SMP_W  = 16;   // normalized component width
    localparam int PROD_W = 32;   // product of two components
    localparam int XY_W   = 35;   // atan2 operands
    localparam int NUM_W  = 34;   // arcsine numerator
    localparam int DEN_W  = 33;   // squared norm
    localparam int Z_W    = 32;   // Q29 angle
    localparam int ARG_W  = 32;   // signed Q30 sine
    localparam int C_W    = 31;   // Q30 cosine
    localparam int OUT_W  = 16;

    localparam int DIV_STEPS  = 30;
    localparam int ROOT_STEPS = 31;
    localparam int FRONT_LAT  = 2;
    localparam int ASIN_LAT   = DIV_STEPS + ROOT_STEPS + 2;
    localparam int UNIT_LAT   = 2;

    localparam logic signed [Z_W-1:0] PI_Q29      = 32'sd1686629713;
    localparam logic signed [Z_W-1:0] HALF_PI_Q29 = 32'sd843314857;
    localparam logic [29:0]           RAD_TO_DEG_Q24 = 30'd961263669;

    localparam logic REG_DEGREE_OUTPUT = 1'b0;

    localparam logic signed [Z_W-1:0] ATAN_Q29 [ATAN_ENTRIES] = '{
        32'sd421657428, 32'sd248918914, 32'sd131521918, 32'sd66762580,
        32'sd33510843,  32'sd16771758,  32'sd8387925,   32'sd4194219,
        32'sd2097141,   32'sd1048575,   32'sd524288,    32'sd262144,
        32'sd131072,    32'sd65536,     32'sd32768,     32'sd16384,
        32'sd8192,      32'sd4096,      32'sd2048,      32'sd1024,
        32'sd512,       32'sd256,       32'sd128,       32'sd64
    };

    typedef struct packed {
        logic                    zero;
        logic                    clamp;
        logic signed [ARG_W-1:0] s;
        logic        [C_W-1:0]   c;
    } t_pitch_arg;

endpackage

/* rtl/quaternion_to_euler_unit.sv */
`timescale 1ns / 1ps
// Top level of the quaternion to ZYX Euler angle converter.
// Depends on qte_pkg, qte_front, qte_asin_prep, qte_cordic and qte_unit.
//
//   Port group      Direction  Handshake
//   quaternion in   in         start, accepted when busy is low
//   angles out      out        o_done strobe, one cycle per word
//   register port   in/out     psel, penable, pwrite, pready
//
// One word enters per cycle; busy stays low. Each word passes through the front
// end, the divider and square root chain, the CORDIC and unit conversion, in
// that order.
// Reset clears the valid bits in every stage and sets degree output.
// A word is presented on o_done for one cycle; there is no backpressure.
module quaternion_to_euler_unit #(
    parameter int CORDIC_STAGES = qte_pkg::DEF_CORDIC_STAGES,
    parameter int SAMPLE_WIDTH  = qte_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_quat_real,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_quat_i,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_quat_j,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_quat_k,
    output logic                             o_done,
    output logic signed [qte_pkg::OUT_W-1:0] o_yaw_angle,
    output logic signed [qte_pkg::OUT_W-1:0] o_pitch_angle,
    output logic signed [qte_pkg::OUT_W-1:0] o_roll_angle,
    output logic                             o_pitch_clamped,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import qte_pkg::*;

    localparam int CORDIC_N  = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
    localparam int CLAMP_LAT = CORDIC_N + 2 + UNIT_LAT;

    logic r_degree;
    logic w_front_vld, w_prep_vld;
    logic signed [XY_W-1:0]  w_yaw_y, w_yaw_x, w_roll_y, w_roll_x;
    logic signed [NUM_W-1:0] w_num;
    logic [DEN_W-1:0]        w_den;
    t_pitch_arg              w_arg;
    logic signed [XY_W-1:0]  w_px, w_py;

    logic signed [XY_W-1:0] r_dl_yy [ASIN_LAT];
    logic signed [XY_W-1:0] r_dl_yx [ASIN_LAT];
    logic signed [XY_W-1:0] r_dl_ry [ASIN_LAT];
    logic signed [XY_W-1:0] r_dl_rx [ASIN_LAT];
    logic                   r_dl_cl [CLAMP_LAT];

    logic w_yaw_cvld;
    logic signed [Z_W-1:0] w_yaw_z, w_pitch_z, w_roll_z;

    assign busy   = 1'b0;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= 1'b1;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_DEGREE_OUTPUT) begin
            r_degree <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_DEGREE_OUTPUT) ? 32'(r_degree) : '0;

    qte_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (start && !busy),
        .i_quat_real (i_quat_real),
        .i_quat_i    (i_quat_i),
        .i_quat_j    (i_quat_j),
        .i_quat_k    (i_quat_k),
        .o_vld       (w_front_vld),
        .o_yaw_y     (w_yaw_y),
        .o_yaw_x     (w_yaw_x),
        .o_roll_y    (w_roll_y),
        .o_roll_x    (w_roll_x),
        .o_num       (w_num),
        .o_den       (w_den)
    );

    qte_asin_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_front_vld),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_vld   (w_prep_vld),
        .o_arg   (w_arg)
    );

    // Yaw and roll operands wait alongside the arcsine preparation.
    always_ff @(posedge i_clk) begin
        r_dl_yy[0] <= w_yaw_y;
        r_dl_yx[0] <= w_yaw_x;
        r_dl_ry[0] <= w_roll_y;
        r_dl_rx[0] <= w_roll_x;
        for (int n = 1; n < ASIN_LAT; n++) begin
            r_dl_yy[n] <= r_dl_yy[n-1];
            r_dl_yx[n] <= r_dl_yx[n-1];
            r_dl_ry[n] <= r_dl_ry[n-1];
            r_dl_rx[n] <= r_dl_rx[n-1];
        end
        r_dl_cl[0] <= w_arg.clamp;
        for (int n = 1; n < CLAMP_LAT; n++) r_dl_cl[n] <= r_dl_cl[n-1];
    end

    // A zero norm forces a zero pitch through the CORDIC zero path.
    assign w_px = w_arg.zero ? '0 : XY_W'(w_arg.c);
    assign w_py = w_arg.zero ? '0 : XY_W'(w_arg.s);

    qte_cordic #(.STAGES(CORDIC_N)) u_cordic_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_prep_vld),
        .i_x     (r_dl_yx[ASIN_LAT-1]),
        .i_y     (r_dl_yy[ASIN_LAT-1]),
        .o_vld   (w_yaw_cvld),
        .o_angle (w_yaw_z)
    );

    qte_cordic #(.STAGES(CORDIC_N)) u_cordic_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_prep_vld),
        .i_x     (w_px),
        .i_y     (w_py),
        .o_vld   (),
        .o_angle (w_pitch_z)
    );

    qte_cordic #(.STAGES(CORDIC_N)) u_cordic_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_prep_vld),
        .i_x     (r_dl_rx[ASIN_LAT-1]),
        .i_y     (r_dl_ry[ASIN_LAT-1]),
        .o_vld   (),
        .o_angle (w_roll_z)
    );

    qte_unit u_unit_yaw (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_yaw_cvld),
        .i_degree (r_degree),
        .i_angle  (w_yaw_z),
        .o_vld    (o_done),
        .o_angle  (o_yaw_angle)
    );

    qte_unit u_unit_pitch (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_yaw_cvld),
        .i_degree (r_degree),
        .i_angle  (w_pitch_z),
        .o_vld    (),
        .o_angle  (o_pitch_angle)
    );

    qte_unit u_unit_roll (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_yaw_cvld),
        .i_degree (r_degree),
        .i_angle  (w_roll_z),
        .o_vld    (),
        .o_angle  (o_roll_angle)
    );

    assign o_pitch_clamped = r_dl_cl[CLAMP_LAT-1];

endmodule

/* rtl/qte_front.sv */
`timescale 1ns / 1ps
// Front end: component normalization, products and the squared-term sums.
// Depends on qte_pkg.
module qte_front #(
    parameter int SAMPLE_WIDTH = qte_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_quat_real,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_quat_i,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_quat_j,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_quat_k,
    output logic                                o_vld,
    output logic signed [qte_pkg::XY_W-1:0]     o_yaw_y,
    output logic signed [qte_pkg::XY_W-1:0]     o_yaw_x,
    output logic signed [qte_pkg::XY_W-1:0]     o_roll_y,
    output logic signed [qte_pkg::XY_W-1:0]     o_roll_x,
    output logic signed [qte_pkg::NUM_W-1:0]    o_num,
    output logic        [qte_pkg::DEN_W-1:0]    o_den
);
    import qte_pkg::*;

    logic signed [SMP_W-1:0] w_r, w_i, w_j, w_k;
    logic signed [PROD_W-1:0] r_rr, r_ii, r_jj, r_kk, r_ij, r_kr, r_jk, r_ir, r_jr, r_ik;
    logic signed [XY_W-1:0]  r_yaw_y, r_yaw_x, r_roll_y, r_roll_x;
    logic signed [NUM_W-1:0] r_num;
    logic [DEN_W-1:0]        r_den;
    logic                    r_vld1, r_vld2;

    // Wide samples keep their top bits, narrow ones are sign extended.
    if (SAMPLE_WIDTH >= SMP_W) begin : g_wide
        assign w_r = i_quat_real[SAMPLE_WIDTH-1 -: SMP_W];
        assign w_i = i_quat_i[SAMPLE_WIDTH-1 -: SMP_W];
        assign w_j = i_quat_j[SAMPLE_WIDTH-1 -: SMP_W];
        assign w_k = i_quat_k[SAMPLE_WIDTH-1 -: SMP_W];
    end else begin : g_narrow
        assign w_r = SMP_W'(i_quat_real);
        assign w_i = SMP_W'(i_quat_i);
        assign w_j = SMP_W'(i_quat_j);
        assign w_k = SMP_W'(i_quat_k);
    end

    always_ff @(posedge i_clk) begin
        r_rr <= w_r * w_r;
        r_ii <= w_i * w_i;
        r_jj <= w_j * w_j;
        r_kk <= w_k * w_k;
        r_ij <= w_i * w_j;
        r_kr <= w_k * w_r;
        r_jk <= w_j * w_k;
        r_ir <= w_i * w_r;
        r_jr <= w_j * w_r;
        r_ik <= w_i * w_k;

        r_yaw_y  <= (XY_W'(r_ij) + XY_W'(r_kr)) <<< 1;
        r_yaw_x  <= XY_W'(r_ii) - XY_W'(r_jj) - XY_W'(r_kk) + XY_W'(r_rr);
        r_roll_y <= (XY_W'(r_jk) + XY_W'(r_ir)) <<< 1;
        r_roll_x <= XY_W'(r_kk) + XY_W'(r_rr) - XY_W'(r_ii) - XY_W'(r_jj);
        r_num    <= (NUM_W'(r_jr) - NUM_W'(r_ik)) <<< 1;
        r_den    <= DEN_W'($unsigned(r_rr)) + DEN_W'($unsigned(r_ii))
                  + DEN_W'($unsigned(r_jj)) + DEN_W'($unsigned(r_kk));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    assign o_vld    = r_vld2;
    assign o_yaw_y  = r_yaw_y;
    assign o_yaw_x  = r_yaw_x;
    assign o_roll_y = r_roll_y;
    assign o_roll_x = r_roll_x;
    assign o_num    = r_num;
    assign o_den    = r_den;

endmodule

/* rtl/qte_asin_prep.sv */
`timescale 1ns / 1ps
// Arcsine operand preparation: pipelined restoring divider for the sine and a
// pipelined digit-by-digit square root for the cosine. Depends on qte_pkg.
module qte_asin_prep (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_vld,
    input  logic signed [qte_pkg::NUM_W-1:0] i_num,
    input  logic        [qte_pkg::DEN_W-1:0] i_den,
    output logic                             o_vld,
    output qte_pkg::t_pitch_arg              o_arg
);
    import qte_pkg::*;

    localparam int DIV_W = DEN_W + 1;
    localparam int SQ_W  = 62;

    logic [DEN_W-1:0] w_an;

    logic [DIV_W-1:0]     r_rem  [DIV_STEPS+1];
    logic [DEN_W-1:0]     r_dv   [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_q    [DIV_STEPS+1];
    logic                 r_dneg [DIV_STEPS+1];
    logic                 r_dzero[DIV_STEPS+1];
    logic                 r_dsat [DIV_STEPS+1];
    logic                 r_dclmp[DIV_STEPS+1];
    logic                 r_dvld [DIV_STEPS+1];

    logic [SQ_W-1:0] r_rv   [ROOT_STEPS+1];
    logic [SQ_W-1:0] r_rs   [ROOT_STEPS+1];
    logic [C_W-1:0]  r_sm   [ROOT_STEPS+1];
    logic            r_rneg [ROOT_STEPS+1];
    logic            r_rzero[ROOT_STEPS+1];
    logic            r_rclmp[ROOT_STEPS+1];
    logic            r_rvld [ROOT_STEPS+1];

    logic [C_W-1:0]  w_smag;
    logic [SQ_W-1:0] w_sq;

    assign w_an = i_num[NUM_W-1] ? DEN_W'(-i_num) : DEN_W'(i_num);

    always_ff @(posedge i_clk) begin
        r_rem[0]   <= DIV_W'(w_an);
        r_dv[0]    <= i_den;
        r_q[0]     <= '0;
        r_dneg[0]  <= i_num[NUM_W-1];
        r_dzero[0] <= (i_den == '0);
        r_dsat[0]  <= (w_an >= i_den);
        r_dclmp[0] <= (w_an > i_den) && (i_den != '0);
    end

    // One quotient bit per stage.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [DIV_W-1:0] w_t;
        logic             w_ge;
        assign w_t  = {r_rem[k][DIV_W-2:0], 1'b0};
        assign w_ge = (w_t >= DIV_W'(r_dv[k]));
        always_ff @(posedge i_clk) begin
            r_rem[k+1]   <= w_ge ? (w_t - DIV_W'(r_dv[k])) : w_t;
            r_dv[k+1]    <= r_dv[k];
            r_q[k+1]     <= {r_q[k][DIV_STEPS-2:0], w_ge};
            r_dneg[k+1]  <= r_dneg[k];
            r_dzero[k+1] <= r_dzero[k];
            r_dsat[k+1]  <= r_dsat[k];
            r_dclmp[k+1] <= r_dclmp[k];
        end
    end

    // A saturated argument is exactly one.
    assign w_smag = r_dsat[DIV_STEPS] ? C_W'(1) << DIV_STEPS : C_W'(r_q[DIV_STEPS]);
    assign w_sq   = SQ_W'(w_smag) * SQ_W'(w_smag);

    always_ff @(posedge i_clk) begin
        r_rv[0]    <= (SQ_W'(1) << (2 * DIV_STEPS)) - w_sq;
        r_rs[0]    <= '0;
        r_sm[0]    <= w_smag;
        r_rneg[0]  <= r_dneg[DIV_STEPS];
        r_rzero[0] <= r_dzero[DIV_STEPS];
        r_rclmp[0] <= r_dclmp[DIV_STEPS];
    end

    // One root bit per stage, from the top bit pair down.
    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_STEPS - 1 - k));
        logic [SQ_W-1:0] w_tr;
        logic            w_ge;
        assign w_tr = r_rs[k] + BIT;
        assign w_ge = (r_rv[k] >= w_tr);
        always_ff @(posedge i_clk) begin
            r_rv[k+1]    <= w_ge ? (r_rv[k] - w_tr) : r_rv[k];
            r_rs[k+1]    <= w_ge ? ((r_rs[k] >> 1) + BIT) : (r_rs[k] >> 1);
            r_sm[k+1]    <= r_sm[k];
            r_rneg[k+1]  <= r_rneg[k];
            r_rzero[k+1] <= r_rzero[k];
            r_rclmp[k+1] <= r_rclmp[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n <= DIV_STEPS; n++) r_dvld[n] <= 1'b0;
            for (int n = 0; n <= ROOT_STEPS; n++) r_rvld[n] <= 1'b0;
        end else begin
            r_dvld[0] <= i_vld;
            for (int n = 0; n < DIV_STEPS; n++) r_dvld[n+1] <= r_dvld[n];
            r_rvld[0] <= r_dvld[DIV_STEPS];
            for (int n = 0; n < ROOT_STEPS; n++) r_rvld[n+1] <= r_rvld[n];
        end
    end

    assign o_vld       = r_rvld[ROOT_STEPS];
    assign o_arg.zero  = r_rzero[ROOT_STEPS];
    assign o_arg.clamp = r_rclmp[ROOT_STEPS];
    assign o_arg.s     = r_rneg[ROOT_STEPS] ? -ARG_W'(r_sm[ROOT_STEPS])
                                            : ARG_W'(r_sm[ROOT_STEPS]);
    assign o_arg.c     = C_W'(r_rs[ROOT_STEPS]);

endmodule

/* rtl/qte_cordic.sv */
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC: four-quadrant arctangent in Q29 radians.
// Depends on qte_pkg for widths and the arctangent table.
module qte_cordic #(
    parameter int STAGES = qte_pkg::DEF_CORDIC_STAGES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_vld,
    input  logic signed [qte_pkg::XY_W-1:0] i_x,
    input  logic signed [qte_pkg::XY_W-1:0] i_y,
    output logic                            o_vld,
    output logic signed [qte_pkg::Z_W-1:0]  o_angle
);
    import qte_pkg::*;

    localparam int CW = XY_W + 2;

    logic signed [CW-1:0]  r_xr  [STAGES+1];
    logic signed [CW-1:0]  r_yr  [STAGES+1];
    logic signed [Z_W-1:0] r_z   [STAGES+1];
    logic                  r_zero[STAGES+1];
    logic                  r_xneg[STAGES+1];
    logic                  r_yneg[STAGES+1];
    logic                  r_vld [STAGES+2];
    logic signed [Z_W-1:0] r_ang;
    logic signed [Z_W-1:0] w_zc, w_zq;

    always_ff @(posedge i_clk) begin
        r_xr[0]   <= i_x[XY_W-1] ? -CW'(i_x) : CW'(i_x);
        r_yr[0]   <= i_y[XY_W-1] ? -CW'(i_y) : CW'(i_y);
        r_z[0]    <= '0;
        r_zero[0] <= (i_x == '0) && (i_y == '0);
        r_xneg[0] <= i_x[XY_W-1];
        r_yneg[0] <= i_y[XY_W-1];
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        logic signed [CW-1:0] w_dx, w_dy;
        assign w_dx = r_yr[i] >>> i;
        assign w_dy = r_xr[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (!r_yr[i][CW-1]) begin
                r_xr[i+1] <= r_xr[i] + w_dx;
                r_yr[i+1] <= r_yr[i] - w_dy;
                r_z[i+1]  <= r_z[i] + ATAN_Q29[i];
            end else begin
                r_xr[i+1] <= r_xr[i] - w_dx;
                r_yr[i+1] <= r_yr[i] + w_dy;
                r_z[i+1]  <= r_z[i] - ATAN_Q29[i];
            end
            r_zero[i+1] <= r_zero[i];
            r_xneg[i+1] <= r_xneg[i];
            r_yneg[i+1] <= r_yneg[i];
        end
    end

    // Clamp to the first quadrant, then fold back by the operand signs.
    always_comb begin
        if (r_z[STAGES][Z_W-1]) begin
            w_zc = '0;
        end else if (r_z[STAGES] > HALF_PI_Q29) begin
            w_zc = HALF_PI_Q29;
        end else begin
            w_zc = r_z[STAGES];
        end
        w_zq = r_xneg[STAGES] ? (PI_Q29 - w_zc) : w_zc;
        if (r_yneg[STAGES]) begin
            w_zq = -w_zq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ang <= r_zero[STAGES] ? '0 : w_zq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < STAGES + 2; n++) r_vld[n] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
            for (int n = 0; n < STAGES + 1; n++) r_vld[n+1] <= r_vld[n];
        end
    end

    assign o_vld   = r_vld[STAGES+1];
    assign o_angle = r_ang;

endmodule

/* rtl/qte_unit.sv */
`timescale 1ns / 1ps
// Output unit conversion: Q29 radians to Q13 radians or 1/128 degree, with
// round half away from zero. Depends on qte_pkg.
module qte_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_vld,
    input  logic                             i_degree,
    input  logic signed [qte_pkg::Z_W-1:0]   i_angle,
    output logic                             o_vld,
    output logic signed [qte_pkg::OUT_W-1:0] o_angle
);
    import qte_pkg::*;

    localparam int M_W  = Z_W - 1;
    localparam int PR_W = M_W + 30;
    localparam int SH   = 46;

    logic [M_W-1:0]  w_mag;
    logic [PR_W-1:0] r_pr;
    logic            r_neg;
    logic            r_vld1, r_vld2;
    logic [PR_W:0]   w_sum;
    logic [OUT_W-1:0] w_r, w_sat;
    logic signed [OUT_W-1:0] r_out;

    assign w_mag = i_angle[Z_W-1] ? M_W'(-i_angle) : M_W'(i_angle);

    // Radians use a shift by 30 so both units share the same rounding shift.
    always_ff @(posedge i_clk) begin
        r_pr  <= i_degree ? PR_W'(w_mag) * PR_W'(RAD_TO_DEG_Q24)
                          : PR_W'(w_mag) << 30;
        r_neg <= i_angle[Z_W-1];
    end

    assign w_sum = (PR_W + 1)'(r_pr) + ((PR_W + 1)'(1) << (SH - 1));
    assign w_r   = w_sum[PR_W:SH];
    assign w_sat = w_r[OUT_W-1] ? {1'b0, {(OUT_W-1){1'b1}}} : w_r;

    always_ff @(posedge i_clk) begin
        r_out <= r_neg ? -$signed(w_sat) : $signed(w_sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    assign o_vld   = r_vld2;
    assign o_angle = r_out;

endmodule

/* rtl/qte_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for quaternion_to_euler_unit, attached by bind.
// Depends on qte_pkg for the pipeline latencies.
module qte_checker #(
    parameter int CORDIC_STAGES = qte_pkg::DEF_CORDIC_STAGES
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             o_done,
    input logic signed [qte_pkg::OUT_W-1:0] o_yaw_angle,
    input logic signed [qte_pkg::OUT_W-1:0] o_pitch_angle,
    input logic signed [qte_pkg::OUT_W-1:0] o_roll_angle,
    input logic                             o_pitch_clamped
);
    import qte_pkg::*;

    localparam int CORDIC_N = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
    localparam int LAT      = FRONT_LAT + ASIN_LAT + CORDIC_N + 2 + UNIT_LAT;

    // Every word out traces back to a word accepted a fixed time earlier.
    a_done_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result word without a matching accepted word");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised on a fully pipelined converter");

    a_clamp_vertical: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_pitch_clamped) |-> (o_pitch_angle >= 16'sd11000
                                         || o_pitch_angle <= -16'sd11000))
        else $error("clamped pitch is not vertical");

    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_yaw_angle <= 16'sd25736 && o_yaw_angle >= -16'sd25736
                    && o_roll_angle <= 16'sd25736 && o_roll_angle >= -16'sd25736))
        else $error("yaw or roll outside plus or minus pi");

endmodule

bind quaternion_to_euler_unit qte_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_qte_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_yaw_angle     (o_yaw_angle),
    .o_pitch_angle   (o_pitch_angle),
    .o_roll_angle    (o_roll_angle),
    .o_pitch_clamped (o_pitch_clamped)
);
